@@ rtl/tsib_pkg.sv @@
// Shared types and constants for the timed sample interpolation buffer.
`timescale 1ns / 1ps
package tsib_pkg;

  // Default ring depth
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_RESET  = 3'd1;
  localparam logic [2:0] OP_PUSH   = 3'd2;
  localparam logic [2:0] OP_PRUNE  = 3'd3;
  localparam logic [2:0] OP_INTERP = 3'd4;
  localparam logic [2:0] OP_LATEST = 3'd5;

  localparam int POS_W  = 32;
  localparam int TIME_W = 48;
  localparam int ALPHA_W = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // One stored sample
  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One request as it travels from the front to the back
  typedef struct packed {
    logic [2:0]        operation;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TIME_W-1:0] sample_time;
    logic [TIME_W-1:0] cutoff_time;
    logic [TIME_W-1:0] target_time;
  } req_t;

  // Divider handshake
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] span;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/tsib_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tsib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tsib_front.sv @@
// Front end: accepts requests, drops unused operation codes, queues the rest.
`timescale 1ns / 1ps
module tsib_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsib_pkg::req_t  in_req,
  output logic            q_valid,
  output tsib_pkg::req_t  q_req,
  input  logic            q_pop
);

  tsib_pkg::req_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep;
  logic       push;
  logic       pop;

  // Classify: only defined operations enter the queue
  always_comb begin
    case (in_req.operation)
      tsib_pkg::OP_CLEAR, tsib_pkg::OP_RESET, tsib_pkg::OP_PUSH,
      tsib_pkg::OP_PRUNE, tsib_pkg::OP_INTERP, tsib_pkg::OP_LATEST: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_req    = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

@@ rtl/tsib_div.sv @@
// Restoring divider for alpha = floor(elapsed * 2^16 / span), one bit a cycle.
`timescale 1ns / 1ps
module tsib_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tsib_pkg::div_cmd_t  cmd,
  output tsib_pkg::div_rsp_t  rsp
);

  localparam int RW = tsib_pkg::TIME_W + 1;
  localparam int QW = tsib_pkg::ALPHA_W;
  localparam int CNTW = $clog2(QW + 1);

  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [tsib_pkg::TIME_W-1:0]   span_r, span_nxt;
  logic [QW-1:0]                 quo_r, quo_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic                          ge;
  logic [RW-1:0]                 kept;

  // One trial subtract per cycle
  always_comb begin
    ge       = (rem_r >= {1'b0, span_r});
    kept     = ge ? (rem_r - {1'b0, span_r}) : rem_r;
    rem_nxt  = rem_r;
    span_nxt = span_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      rem_nxt  = {1'b0, cmd.elapsed};
      span_nxt = cmd.span;
      quo_nxt  = '0;
      cnt_nxt  = CNTW'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt  = {kept[RW-2:0], 1'b0};
      quo_nxt  = {quo_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    span_r <= span_nxt;
    quo_r  <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ rtl/tsib_back.sv @@
// Back end: sequencer that runs each request against the sample ring.
`timescale 1ns / 1ps
module tsib_back #(
  parameter int DEPTH = tsib_pkg::DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tsib_pkg::req_t  q_req,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_has,
  output logic [31:0]     out_x,
  output logic [31:0]     out_y
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PUSH     = 4'd1;
  localparam logic [3:0] S_PRUNE_RD = 4'd2;
  localparam logic [3:0] S_PRUNE    = 4'd3;
  localparam logic [3:0] S_LAST     = 4'd4;
  localparam logic [3:0] S_FIRST    = 4'd5;
  localparam logic [3:0] S_LASTCHK  = 4'd6;
  localparam logic [3:0] S_SCAN     = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_MUL      = 4'd9;
  localparam logic [3:0] S_ADD      = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  tsib_pkg::req_t   req_r, req_nxt;
  tsib_pkg::entry_t prev_r, prev_nxt;
  tsib_pkg::entry_t cur_r, cur_nxt;
  logic [tsib_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic signed [50:0] prod_x_r, prod_x_nxt;
  logic signed [50:0] prod_y_r, prod_y_nxt;
  logic          res_has_r, res_has_nxt;
  logic [31:0]   res_x_r, res_x_nxt;
  logic [31:0]   res_y_r, res_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_has_r, out_has_nxt;
  logic [31:0]   out_x_r, out_x_nxt;
  logic [31:0]   out_y_r, out_y_nxt;

  logic                      we;
  logic [AW-1:0]             waddr;
  tsib_pkg::entry_t          wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic [tsib_pkg::ENTRY_W-1:0] rdata;
  tsib_pkg::entry_t          rd;
  tsib_pkg::div_cmd_t        div_cmd;
  tsib_pkg::div_rsp_t        div_rsp;

  // Slot of the i-th oldest sample
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(i);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // Round, add and saturate one blended coordinate
  function automatic logic [31:0] finish(input logic [31:0] a,
                                         input logic signed [50:0] prod);
    logic signed [50:0] t;
    logic signed [35:0] r;
    t = prod + 51'sd32768;
    r = 36'($signed({{4{a[31]}}, a})) + 36'(t >>> 16);
    if (r > 36'sd2147483647) return 32'h7fffffff;
    if (r < -36'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  assign rd = tsib_pkg::entry_t'(rdata);

  tsib_ram #(
    .WIDTH (tsib_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsib_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    alpha_nxt     = alpha_r;
    prod_x_nxt    = prod_x_r;
    prod_y_nxt    = prod_y_r;
    res_has_nxt   = res_has_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_has_nxt   = out_has_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    div_cmd       = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          req_nxt = q_req;
          case (q_req.operation)
            tsib_pkg::OP_CLEAR: begin
              oldest_nxt = '0;
              count_nxt  = '0;
            end
            tsib_pkg::OP_RESET: begin
              we         = 1'b1;
              waddr      = '0;
              wdata      = {q_req.sample_time, q_req.pos_y, q_req.pos_x};
              oldest_nxt = '0;
              count_nxt  = CW'(1);
            end
            tsib_pkg::OP_PUSH: begin
              if (count_r == '0) begin
                we        = 1'b1;
                waddr     = oldest_r;
                wdata     = {q_req.sample_time, q_req.pos_y, q_req.pos_x};
                count_nxt = CW'(1);
              end else begin
                re        = 1'b1;
                raddr     = slot_of(oldest_r, count_r - 1'b1);
                state_nxt = S_PUSH;
              end
            end
            tsib_pkg::OP_PRUNE: begin
              if (count_r >= CW'(2)) begin
                re        = 1'b1;
                raddr     = slot_of(oldest_r, CW'(1));
                state_nxt = S_PRUNE;
              end
            end
            tsib_pkg::OP_INTERP, tsib_pkg::OP_LATEST: begin
              if (count_r == '0) begin
                res_has_nxt = 1'b0;
                res_x_nxt   = '0;
                res_y_nxt   = '0;
                state_nxt   = S_OUT;
              end else if (q_req.operation == tsib_pkg::OP_LATEST) begin
                re        = 1'b1;
                raddr     = slot_of(oldest_r, count_r - 1'b1);
                state_nxt = S_LAST;
              end else begin
                re        = 1'b1;
                raddr     = oldest_r;
                state_nxt = S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end

      // Drop older, overwrite equal, append or evict otherwise
      S_PUSH: begin
        state_nxt = S_IDLE;
        wdata     = {req_r.sample_time, req_r.pos_y, req_r.pos_x};
        if (req_r.sample_time == rd.sample_time) begin
          we    = 1'b1;
          waddr = slot_of(oldest_r, count_r - 1'b1);
        end else if (req_r.sample_time > rd.sample_time) begin
          we = 1'b1;
          if (count_r == CW'(DEPTH)) begin
            waddr      = oldest_r;
            oldest_nxt = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
          end else begin
            waddr     = slot_of(oldest_r, count_r);
            count_nxt = count_r + 1'b1;
          end
        end
      end

      S_PRUNE_RD: begin
        if (count_r >= CW'(2)) begin
          re        = 1'b1;
          raddr     = slot_of(oldest_r, CW'(1));
          state_nxt = S_PRUNE;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_PRUNE: begin
        if (rd.sample_time <= req_r.cutoff_time) begin
          oldest_nxt = (oldest_r == AW'(DEPTH - 1)) ? '0 : oldest_r + 1'b1;
          count_nxt  = count_r - 1'b1;
          state_nxt  = S_PRUNE_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_LAST: begin
        res_has_nxt = 1'b1;
        res_x_nxt   = rd.pos_x;
        res_y_nxt   = rd.pos_y;
        state_nxt   = S_OUT;
      end

      // Clamp to the first sample, else read the last sample
      S_FIRST: begin
        if (req_r.target_time <= rd.sample_time) begin
          res_has_nxt = 1'b1;
          res_x_nxt   = rd.pos_x;
          res_y_nxt   = rd.pos_y;
          state_nxt   = S_OUT;
        end else begin
          prev_nxt  = rd;
          re        = 1'b1;
          raddr     = slot_of(oldest_r, count_r - 1'b1);
          state_nxt = S_LASTCHK;
        end
      end

      // Clamp to the last sample, else start the bracket search
      S_LASTCHK: begin
        if (req_r.target_time >= rd.sample_time) begin
          res_has_nxt = 1'b1;
          res_x_nxt   = rd.pos_x;
          res_y_nxt   = rd.pos_y;
          state_nxt   = S_OUT;
        end else begin
          idx_nxt   = CW'(1);
          re        = 1'b1;
          raddr     = slot_of(oldest_r, CW'(1));
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if ((idx_r < count_r - 1'b1) && (rd.sample_time < req_r.target_time)) begin
          prev_nxt = rd;
          idx_nxt  = idx_r + 1'b1;
          re       = 1'b1;
          raddr    = slot_of(oldest_r, idx_r + 1'b1);
        end else begin
          cur_nxt = rd;
          if (rd.sample_time <= prev_r.sample_time) begin
            res_has_nxt = 1'b1;
            res_x_nxt   = rd.pos_x;
            res_y_nxt   = rd.pos_y;
            state_nxt   = S_OUT;
          end else begin
            div_cmd.start   = 1'b1;
            div_cmd.elapsed = (req_r.target_time > prev_r.sample_time) ?
                              req_r.target_time - prev_r.sample_time : '0;
            div_cmd.span    = rd.sample_time - prev_r.sample_time;
            state_nxt       = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          alpha_nxt = (div_rsp.quotient > tsib_pkg::ALPHA_ONE) ?
                      tsib_pkg::ALPHA_ONE : div_rsp.quotient;
          state_nxt = S_MUL;
        end
      end

      // Scale the differences by alpha
      S_MUL: begin
        prod_x_nxt = ($signed({cur_r.pos_x[31], cur_r.pos_x}) -
                      $signed({prev_r.pos_x[31], prev_r.pos_x})) *
                     $signed({1'b0, alpha_r});
        prod_y_nxt = ($signed({cur_r.pos_y[31], cur_r.pos_y}) -
                      $signed({prev_r.pos_y[31], prev_r.pos_y})) *
                     $signed({1'b0, alpha_r});
        state_nxt  = S_ADD;
      end

      S_ADD: begin
        res_has_nxt = 1'b1;
        res_x_nxt   = finish(prev_r.pos_x, prod_x_r);
        res_y_nxt   = finish(prev_r.pos_y, prod_y_r);
        state_nxt   = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_has_nxt   = res_has_r;
          out_x_nxt     = res_x_r;
          out_y_nxt     = res_y_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    req_r     <= req_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    alpha_r   <= alpha_nxt;
    prod_x_r  <= prod_x_nxt;
    prod_y_r  <= prod_y_nxt;
    res_has_r <= res_has_nxt;
    res_x_r   <= res_x_nxt;
    res_y_r   <= res_y_nxt;
    out_has_r <= out_has_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_has   = out_has_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule

@@ rtl/timed_sample_interpolation_buffer_unit.sv @@
// Top level of the timed sample interpolation buffer.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one request per accepted transfer. in_tuser carries the operation
//           (clear, reset, push, prune, interpolate, latest); in_tdata the sample
//           position, sample time, prune cutoff and interpolation target.
//   out_* : one result for each interpolate or latest request, none for the
//           others. out_tuser is has_position, out_tdata the x and y position.
//   A two-entry request queue sits in front of the sequencer, so requests are
//   taken while a result waits in the output register.
//   Steps per request (one-read-port sample RAM): clear and reset need no
//   read; push reads the newest sample, then writes (direct write into an
//   empty ring); prune reads and drops samples one by one; latest reads the
//   newest sample; a query on an empty ring goes straight to the output;
//   interpolate does first and last clamp reads, a bracket scan at one RAM
//   read a cycle, a bit-serial divide for alpha, multiply, round and hand-off.
//   Reset (rst_n low, synchronous) empties the ring and the queue and drops
//   any pending result; sample RAM contents are not cleared.
//   A stalled receiver (out_tready low) holds the result; the sequencer then
//   waits and the queue fills, after which in_tready falls.
module timed_sample_interpolation_buffer_unit #(
  parameter int DEPTH = tsib_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[2:0]
  input  logic [2:0]   in_tuser,
  // pos_x[31:0], pos_y[63:32], sample_time[111:64], cutoff_time[159:112],
  // target_time[207:160]
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // has_position[0]
  output logic         out_tuser,
  // result_x[31:0], result_y[63:32]
  output logic [63:0]  out_tdata
);

  tsib_pkg::req_t in_req;
  tsib_pkg::req_t q_req;
  logic           q_valid;
  logic           q_pop;
  logic [31:0]    res_x;
  logic [31:0]    res_y;

  // Unpack the request
  always_comb begin
    in_req.operation   = in_tuser;
    in_req.pos_x       = in_tdata[31:0];
    in_req.pos_y       = in_tdata[63:32];
    in_req.sample_time = in_tdata[111:64];
    in_req.cutoff_time = in_tdata[159:112];
    in_req.target_time = in_tdata[207:160];
  end

  tsib_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_pop    (q_pop)
  );

  tsib_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_has   (out_tuser),
    .out_x     (res_x),
    .out_y     (res_y)
  );

  assign out_tdata = {res_y, res_x};

endmodule

@@ bench/tsib_checker.sv @@
// Checker for the timed sample interpolation buffer: predicts and compares results.
`timescale 1ns / 1ps
module tsib_checker #(
  parameter int DEPTH = tsib_pkg::DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [2:0]   in_tuser,
  input  logic [207:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         out_tuser,
  input  logic [63:0]  out_tdata,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  typedef struct packed {
    logic        has_pos;
    logic [31:0] rx;
    logic [31:0] ry;
  } position_t;

  logic [31:0] ring_x [DEPTH];
  logic [31:0] ring_y [DEPTH];
  logic [47:0] ring_t [DEPTH];
  int head_slot;
  int live_count;
  position_t expected_positions[$];

  function automatic int slot_at(int i);
    return (head_slot + i) % DEPTH;
  endfunction

  // Blend a toward b by alpha (Q1.16), round half up, saturate to 32 bits
  function automatic logic [31:0] lerp_sat(logic [31:0] a, logic [31:0] b,
                                           logic [16:0] alpha);
    longint sa, sb, prod, r;
    sa = longint'(signed'(a));
    sb = longint'(signed'(b));
    prod = (sb - sa) * longint'(alpha) + 32768;
    r = sa + (prod >>> 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Apply one request to the shadow ring; queue a position if one results
  task automatic apply_request(logic [2:0] op, logic [207:0] d);
    logic [31:0] px, py;
    logic [47:0] st, cut, tgt, span, elapsed;
    logic [63:0] alpha;
    int last, lo, hi, i, s;
    position_t p;
    px = d[31:0];
    py = d[63:32];
    st = d[111:64];
    cut = d[159:112];
    tgt = d[207:160];
    p = '0;
    case (op)
      tsib_pkg::OP_CLEAR: begin
        head_slot = 0;
        live_count = 0;
      end
      tsib_pkg::OP_RESET: begin
        head_slot = 0;
        live_count = 1;
        ring_x[0] = px;
        ring_y[0] = py;
        ring_t[0] = st;
      end
      tsib_pkg::OP_PUSH: begin
        if (live_count > 0) begin
          last = slot_at(live_count - 1);
          if (st < ring_t[last]) return;
          if (st == ring_t[last]) begin
            ring_x[last] = px;
            ring_y[last] = py;
            return;
          end
        end
        if (live_count >= DEPTH) begin
          s = head_slot;
          head_slot = (head_slot + 1) % DEPTH;
        end else begin
          s = slot_at(live_count);
          live_count++;
        end
        ring_x[s] = px;
        ring_y[s] = py;
        ring_t[s] = st;
      end
      tsib_pkg::OP_PRUNE: begin
        while (live_count >= 2 && ring_t[slot_at(1)] <= cut) begin
          head_slot = (head_slot + 1) % DEPTH;
          live_count--;
        end
      end
      tsib_pkg::OP_INTERP: begin
        if (live_count > 0) begin
          lo = slot_at(0);
          last = slot_at(live_count - 1);
          p.has_pos = 1'b1;
          if (tgt <= ring_t[lo]) begin
            p.rx = ring_x[lo];
            p.ry = ring_y[lo];
          end else if (tgt >= ring_t[last]) begin
            p.rx = ring_x[last];
            p.ry = ring_y[last];
          end else begin
            i = 1;
            while (i < live_count - 1 && ring_t[slot_at(i)] < tgt) i++;
            hi = slot_at(i);
            lo = slot_at(i - 1);
            span = ring_t[hi] - ring_t[lo];
            elapsed = tgt - ring_t[lo];
            alpha = ({16'd0, elapsed} << 16) / {16'd0, span};
            if (alpha > 64'h10000) alpha = 64'h10000;
            p.rx = lerp_sat(ring_x[lo], ring_x[hi], alpha[16:0]);
            p.ry = lerp_sat(ring_y[lo], ring_y[hi], alpha[16:0]);
          end
        end
        expected_positions = {expected_positions, p};
      end
      tsib_pkg::OP_LATEST: begin
        if (live_count > 0) begin
          last = slot_at(live_count - 1);
          p = '{1'b1, ring_x[last], ring_y[last]};
        end
        expected_positions = {expected_positions, p};
      end
      default: ;
    endcase
  endtask

  assign pending = expected_positions.size();

  // Predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    position_t want;
    if (!rst_n) begin
      head_slot = 0;
      live_count = 0;
      fail_count <= 0;
      results_seen <= 0;
      expected_positions.delete();
    end else begin
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_positions.size() == 0) begin
          if (fail_count < 10) $display("unexpected result at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_positions[0];
          expected_positions.delete(0);
          if (want.has_pos !== out_tuser || want.rx !== out_tdata[31:0] ||
              want.ry !== out_tdata[63:32]) begin
            if (fail_count < 10)
              $display("mismatch at %0t: expected has=%0b x=%h y=%h, got has=%0b x=%h y=%h",
                       $realtime, want.has_pos, want.rx, want.ry, out_tuser,
                       out_tdata[31:0], out_tdata[63:32]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Stimulus and verdict for the timed sample interpolation buffer.
`timescale 1ns / 1ps
module tb_top;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [2:0]   in_tuser = tsib_pkg::OP_CLEAR;
  logic [207:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         out_tuser;
  logic [63:0]  out_tdata;
  int fail_count, pending, results_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int sent_items = 0;
  logic [47:0] clock_now = 48'd1000;

  always #5 clk = ~clk;

  timed_sample_interpolation_buffer_unit dut (.*);

  tsib_checker chk (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tuser(out_tuser), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 800000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) begin
      hold_cycles <= hold_cycles + 1;
      out_tready <= 1'b0;
    end else begin
      hold_cycles <= 0;
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request, with random idle cycles ahead of it
  task automatic send(logic [2:0] op, logic [31:0] px, logic [31:0] py,
                      logic [47:0] st, logic [47:0] cut, logic [47:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {tgt, cut, st, py, px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(1) ? 32'sd65536 * $signed($urandom_range(200) - 100) : 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] rand_wide();
    return 48'({$urandom, $urandom});
  endfunction

  // One random request, mostly a well-formed timeline around clock_now
  task automatic random_request();
    int r;
    logic [47:0] t;
    r = $urandom_range(99);
    if (r < 45) begin
      clock_now = clock_now + ($urandom_range(9) == 0 ? 48'd0 : 48'($urandom_range(50000)));
      t = ($urandom_range(15) == 0) ? clock_now - 48'($urandom_range(3000)) : clock_now;
      send(tsib_pkg::OP_PUSH, rand_pos(), rand_pos(), t, rand_wide(), rand_wide());
    end else if (r < 75) begin
      t = clock_now - 48'($urandom_range(400000));
      if ($urandom_range(9) == 0) t = rand_wide();
      send(tsib_pkg::OP_INTERP, $urandom, $urandom, rand_wide(), rand_wide(), t);
    end else if (r < 85) begin
      send(tsib_pkg::OP_LATEST, $urandom, $urandom, rand_wide(), rand_wide(), rand_wide());
    end else if (r < 93) begin
      t = ($urandom_range(4) == 0) ? rand_wide() : clock_now - 48'($urandom_range(300000));
      send(tsib_pkg::OP_PRUNE, $urandom, $urandom, rand_wide(), t, rand_wide());
    end else if (r < 96) begin
      clock_now = ($urandom_range(3) == 0) ? rand_wide() : clock_now + 48'd7;
      send(tsib_pkg::OP_RESET, rand_pos(), rand_pos(), clock_now, rand_wide(), rand_wide());
    end else if (r < 98) begin
      send(tsib_pkg::OP_CLEAR, $urandom, $urandom, rand_wide(), rand_wide(), rand_wide());
    end else begin
      send(3'($urandom_range(7, 6)), $urandom, $urandom, rand_wide(), rand_wide(),
           rand_wide());
    end
  endtask

  task automatic drain();
    go_idle();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty queries, extremes, overwrite, stale push, eviction, prune
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd5);
    send(tsib_pkg::OP_LATEST, '0, '0, '0, '0, '0);
    send(tsib_pkg::OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 48'd100, '0, '0);
    send(tsib_pkg::OP_PUSH, 32'h8000_0000, 32'h7FFF_FFFF, 48'd200, '0, '0);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd150);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd50);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send(tsib_pkg::OP_PUSH, 32'd1, 32'd2, 48'd200, '0, '0);
    send(tsib_pkg::OP_PUSH, 32'd9, 32'd9, 48'd150, '0, '0);
    send(tsib_pkg::OP_LATEST, '0, '0, '0, '0, '0);
    send(tsib_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0, '0);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd201);
    for (int i = 0; i < 18; i++)
      send(tsib_pkg::OP_RESET + 3'(i != 0), 32'sd65536 * i, -32'sd3 * i,
           48'd10 * i + 48'd7, '0, '0);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd93);
    send(tsib_pkg::OP_PRUNE, '0, '0, '0, 48'd120, '0);
    send(tsib_pkg::OP_INTERP, '0, '0, '0, '0, 48'd110);
    send(tsib_pkg::OP_PRUNE, '0, '0, '0, 48'hFFFF_FFFF_FFFF, '0);
    send(tsib_pkg::OP_LATEST, '0, '0, '0, '0, '0);
    send(3'd6, '0, '0, '0, '0, '0);
    send(3'd7, '0, '0, '0, '0, '0);
    send(tsib_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    send(tsib_pkg::OP_LATEST, '0, '0, '0, '0, '0);
    // Sender pause until every result is back
    drain();

    // Random phases with different idle mixes
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 68 : 28) : 0;
      recv_stall_pct = (phase == 2) ? 68 : (phase == 3 ? 28 : 0);
      for (int n = 0; n < 220; n++) random_request();
    end

    // Long receiver hold-off while requests keep coming, so in_tready drops
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(1)) send(tsib_pkg::OP_LATEST, '0, '0, '0, '0, '0);
        else random_request();
      end
      while (hold_cycles < 400) @(posedge clk);
    join_any
    while (hold_cycles < 400) @(posedge clk);
    hold_off = 1'b0;
    wait fork;
    drain();

    $display("ran %0d requests and checked %0d results across idle/stall mixes",
             sent_items, results_seen);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tsib_pkg.sv
rtl/tsib_ram.sv
rtl/tsib_front.sv
rtl/tsib_div.sv
rtl/tsib_back.sv
rtl/timed_sample_interpolation_buffer_unit.sv
bench/tsib_checker.sv
bench/tb_top.sv
